FILE: rtl/spa_pkg.sv
// Shared definitions for the sparse polynomial adder: field widths, command codes,
// the default buffer depth and the sequencer status struct.
// No dependencies.
package spa_pkg;

    // field widths
    localparam int CMD_W  = 2;
    localparam int COEF_W = 16;
    localparam int EXP_W  = 10;
    localparam int SUM_W  = 17;

    // default term buffer depth
    localparam int TERM_DEPTH_DEF = 32;

    // command codes
    localparam logic [CMD_W-1:0] CMD_APPEND_A = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND_B = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COMPUTE  = 2'd2;

    // status from the merge sequencer to the top level
    typedef struct packed {
        logic idle;   // ready for a new command
        logic clear;  // end of a compute run: empty buffers, clear drop record
    } t_merge_stat;

endpackage

FILE: rtl/spa_if.sv
// Valid/ready channel interfaces for the sparse polynomial adder.
// Depends on spa_pkg for field widths.
interface spa_in_if;
    logic                             valid;
    logic                             ready;
    logic [spa_pkg::CMD_W-1:0]        command;
    logic signed [spa_pkg::COEF_W-1:0] coef;
    logic [spa_pkg::EXP_W-1:0]        exponent;

    modport source (output valid, command, coef, exponent, input ready);
    modport sink   (input valid, command, coef, exponent, output ready);
endinterface

interface spa_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [spa_pkg::SUM_W-1:0] sum_coef;
    logic [spa_pkg::EXP_W-1:0]        sum_exponent;
    logic                             term_valid;
    logic                             last;
    logic                             overflow;

    modport source (output valid, sum_coef, sum_exponent, term_valid, last, overflow,
                    input ready);
    modport sink   (input valid, sum_coef, sum_exponent, term_valid, last, overflow,
                    output ready);
endinterface

FILE: rtl/spa_term_buf.sv
// One term buffer: coefficient/exponent memory with a fill count and a registered
// read port. Depends on spa_pkg.
module spa_term_buf #(
    parameter int TERM_DEPTH = spa_pkg::TERM_DEPTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_wr,
    input  logic signed [spa_pkg::COEF_W-1:0]     i_wr_coef,
    input  logic [spa_pkg::EXP_W-1:0]             i_wr_exp,
    input  logic                                  i_clr,
    input  logic [((TERM_DEPTH > 1) ? $clog2(TERM_DEPTH) : 1)-1:0] i_rd_addr,
    output logic signed [spa_pkg::COEF_W-1:0]     o_rd_coef,
    output logic [spa_pkg::EXP_W-1:0]             o_rd_exp,
    output logic [$clog2(TERM_DEPTH+1)-1:0]       o_count,
    output logic                                  o_full
);
    localparam int CW = $clog2(TERM_DEPTH + 1);
    localparam int AW = (TERM_DEPTH > 1) ? $clog2(TERM_DEPTH) : 1;

    logic [spa_pkg::COEF_W-1:0] r_coef_mem [2**AW];
    logic [spa_pkg::EXP_W-1:0]  r_exp_mem  [2**AW];
    logic [spa_pkg::COEF_W-1:0] r_rd_coef;
    logic [spa_pkg::EXP_W-1:0]  r_rd_exp;
    logic [CW-1:0]              r_count, n_count;

    assign o_full    = (r_count == CW'(TERM_DEPTH));
    assign o_count   = r_count;
    assign o_rd_coef = signed'(r_rd_coef);
    assign o_rd_exp  = r_rd_exp;

    // fill count: appends past the depth are dropped
    always_comb begin
        n_count = r_count;
        if (i_clr) begin
            n_count = '0;
        end else if (i_wr && !o_full) begin
            n_count = r_count + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // memory write at the fill position, registered read
    always_ff @(posedge i_clk) begin
        if (i_wr && !o_full) begin
            r_coef_mem[r_count[AW-1:0]] <= unsigned'(i_wr_coef);
            r_exp_mem[r_count[AW-1:0]]  <= i_wr_exp;
        end
        r_rd_coef <= r_coef_mem[i_rd_addr];
        r_rd_exp  <= r_exp_mem[i_rd_addr];
    end

endmodule

FILE: rtl/spa_merge.sv
// Merge sequencer: walks both term buffers with one shared compare/add unit,
// holds one term back to mark the last result, drives the output register.
// Depends on spa_pkg and spa_out_if.
module spa_merge #(
    parameter int TERM_DEPTH = spa_pkg::TERM_DEPTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic [$clog2(TERM_DEPTH+1)-1:0]       i_cnt_a,
    input  logic [$clog2(TERM_DEPTH+1)-1:0]       i_cnt_b,
    input  logic signed [spa_pkg::COEF_W-1:0]     i_coef_a,
    input  logic [spa_pkg::EXP_W-1:0]             i_exp_a,
    input  logic signed [spa_pkg::COEF_W-1:0]     i_coef_b,
    input  logic [spa_pkg::EXP_W-1:0]             i_exp_b,
    input  logic                                  i_drop,
    output logic [((TERM_DEPTH > 1) ? $clog2(TERM_DEPTH) : 1)-1:0] o_addr_a,
    output logic [((TERM_DEPTH > 1) ? $clog2(TERM_DEPTH) : 1)-1:0] o_addr_b,
    output spa_pkg::t_merge_stat                  o_stat,
    spa_out_if.source                             o_res
);
    localparam int CW = $clog2(TERM_DEPTH + 1);
    localparam int AW = (TERM_DEPTH > 1) ? $clog2(TERM_DEPTH) : 1;
    localparam int SW = spa_pkg::SUM_W;
    localparam int EW = spa_pkg::EXP_W;

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_CMP  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]           r_state, n_state;
    logic [CW-1:0]        r_a, n_a, r_b, n_b;
    // held-back term
    logic                 r_pend_v, n_pend_v;
    logic signed [SW-1:0] r_pend_coef, n_pend_coef;
    logic [EW-1:0]        r_pend_exp, n_pend_exp;
    // output register
    logic                 r_out_v, n_out_v;
    logic signed [SW-1:0] r_out_coef, n_out_coef;
    logic [EW-1:0]        r_out_exp, n_out_exp;
    logic                 r_out_tv, n_out_tv;
    logic                 r_out_last, n_out_last;
    logic                 r_out_ovf, n_out_ovf;

    logic                 w_a_ok, w_b_ok, w_slot;
    logic                 w_new;
    logic signed [SW-1:0] w_new_coef;
    logic [EW-1:0]        w_new_exp;
    logic signed [SW-1:0] w_ext_a, w_ext_b, w_sum;

    assign o_addr_a = r_a[AW-1:0];
    assign o_addr_b = r_b[AW-1:0];

    assign w_a_ok = (r_a < i_cnt_a);
    assign w_b_ok = (r_b < i_cnt_b);
    assign w_slot = !r_out_v || o_res.ready;

    // shared compare and add unit
    assign w_ext_a = SW'(i_coef_a);
    assign w_ext_b = SW'(i_coef_b);
    assign w_sum   = w_ext_a + w_ext_b;

    always_comb begin
        n_state     = r_state;
        n_a         = r_a;
        n_b         = r_b;
        n_pend_v    = r_pend_v;
        n_pend_coef = r_pend_coef;
        n_pend_exp  = r_pend_exp;
        n_out_v     = r_out_v && !o_res.ready;
        n_out_coef  = r_out_coef;
        n_out_exp   = r_out_exp;
        n_out_tv    = r_out_tv;
        n_out_last  = r_out_last;
        n_out_ovf   = r_out_ovf;
        w_new       = 1'b0;
        w_new_coef  = w_ext_a;
        w_new_exp   = i_exp_a;
        o_stat.idle  = (r_state == S_IDLE);
        o_stat.clear = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_a     = '0;
                    n_b     = '0;
                    n_state = S_READ;
                end
            end
            // the registered read for the current pointers is taken here; S_CMP sees its data
            S_READ: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (!w_a_ok && !w_b_ok) begin
                    n_state = S_FIN;
                end else if (w_slot) begin
                    n_state = S_READ;
                    if (w_a_ok && (!w_b_ok || i_exp_a > i_exp_b)) begin
                        w_new = 1'b1;
                        n_a   = r_a + CW'(1);
                    end else if (w_b_ok && (!w_a_ok || i_exp_a < i_exp_b)) begin
                        w_new      = 1'b1;
                        w_new_coef = w_ext_b;
                        w_new_exp  = i_exp_b;
                        n_b        = r_b + CW'(1);
                    end else begin
                        // equal exponents: a zero sum drops out
                        w_new      = (w_sum != '0);
                        w_new_coef = w_sum;
                        n_a        = r_a + CW'(1);
                        n_b        = r_b + CW'(1);
                    end
                    if (w_new) begin
                        if (r_pend_v) begin
                            n_out_v    = 1'b1;
                            n_out_coef = r_pend_coef;
                            n_out_exp  = r_pend_exp;
                            n_out_tv   = 1'b1;
                            n_out_last = 1'b0;
                            n_out_ovf  = i_drop;
                        end
                        n_pend_v    = 1'b1;
                        n_pend_coef = w_new_coef;
                        n_pend_exp  = w_new_exp;
                    end
                end
            end
            // final beat: held term, or the empty-sum marker
            S_FIN: begin
                if (w_slot) begin
                    n_out_v    = 1'b1;
                    n_out_coef = r_pend_v ? r_pend_coef : '0;
                    n_out_exp  = r_pend_v ? r_pend_exp : '0;
                    n_out_tv   = r_pend_v;
                    n_out_last = 1'b1;
                    n_out_ovf  = i_drop;
                    n_pend_v   = 1'b0;
                    o_stat.clear = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a         <= n_a;
        r_b         <= n_b;
        r_pend_coef <= n_pend_coef;
        r_pend_exp  <= n_pend_exp;
        r_out_coef  <= n_out_coef;
        r_out_exp   <= n_out_exp;
        r_out_tv    <= n_out_tv;
        r_out_last  <= n_out_last;
        r_out_ovf   <= n_out_ovf;
    end

    assign o_res.valid        = r_out_v;
    assign o_res.sum_coef     = r_out_coef;
    assign o_res.sum_exponent = r_out_exp;
    assign o_res.term_valid   = r_out_tv;
    assign o_res.last         = r_out_last;
    assign o_res.overflow     = r_out_ovf;

endmodule

FILE: rtl/sparse_polynomial_adder_top.sv
// Top level of the sparse polynomial adder: two term buffers, the merge sequencer
// and the drop record. Depends on spa_pkg, spa_if, spa_term_buf, spa_merge.
//
// Append beats (command 0 or 1) store one term each; a term beyond TERM_DEPTH
// is dropped and flagged in the overflow bit of the next compute run. A compute
// beat (command 2) merges the buffers in descending exponent order and drops
// equal-exponent pairs that sum to zero. Each merge step passes through S_READ,
// for the registered read of both buffer memories, and then S_CMP, for the shared
// exponent compare and coefficient add; a step waits in S_CMP while the result
// sink stalls, and the run ends in S_FIN. One result is held back so that the
// final beat carries last; an empty sum gives a single beat with term_valid low.
// The input is not ready during a run. Command 3 is accepted and ignored.
module sparse_polynomial_adder_top #(
    parameter int TERM_DEPTH = spa_pkg::TERM_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    spa_in_if.sink     i_in,
    spa_out_if.source  o_res
);
    localparam int CW = $clog2(TERM_DEPTH + 1);
    localparam int AW = (TERM_DEPTH > 1) ? $clog2(TERM_DEPTH) : 1;

    spa_pkg::t_merge_stat                w_stat;
    logic                                w_acc;
    logic                                w_wr_a, w_wr_b, w_start;
    logic                                w_full_a, w_full_b;
    logic [CW-1:0]                       w_cnt_a, w_cnt_b;
    logic [AW-1:0]                       w_addr_a, w_addr_b;
    logic signed [spa_pkg::COEF_W-1:0]   w_coef_a, w_coef_b;
    logic [spa_pkg::EXP_W-1:0]           w_exp_a, w_exp_b;
    logic                                r_drop, n_drop;

    // command decode
    assign i_in.ready = w_stat.idle;
    assign w_acc   = i_in.valid && i_in.ready;
    assign w_wr_a  = w_acc && (i_in.command == spa_pkg::CMD_APPEND_A);
    assign w_wr_b  = w_acc && (i_in.command == spa_pkg::CMD_APPEND_B);
    assign w_start = w_acc && (i_in.command == spa_pkg::CMD_COMPUTE);

    // drop record, cleared at the end of each run
    always_comb begin
        n_drop = r_drop;
        if (w_stat.clear) begin
            n_drop = 1'b0;
        end else if ((w_wr_a && w_full_a) || (w_wr_b && w_full_b)) begin
            n_drop = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drop <= 1'b0;
        end else begin
            r_drop <= n_drop;
        end
    end

    spa_term_buf #(.TERM_DEPTH(TERM_DEPTH)) u_buf_a (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_wr_a),
        .i_wr_coef (i_in.coef),
        .i_wr_exp  (i_in.exponent),
        .i_clr     (w_stat.clear),
        .i_rd_addr (w_addr_a),
        .o_rd_coef (w_coef_a),
        .o_rd_exp  (w_exp_a),
        .o_count   (w_cnt_a),
        .o_full    (w_full_a)
    );

    spa_term_buf #(.TERM_DEPTH(TERM_DEPTH)) u_buf_b (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_wr_b),
        .i_wr_coef (i_in.coef),
        .i_wr_exp  (i_in.exponent),
        .i_clr     (w_stat.clear),
        .i_rd_addr (w_addr_b),
        .o_rd_coef (w_coef_b),
        .o_rd_exp  (w_exp_b),
        .o_count   (w_cnt_b),
        .o_full    (w_full_b)
    );

    spa_merge #(.TERM_DEPTH(TERM_DEPTH)) u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_cnt_a  (w_cnt_a),
        .i_cnt_b  (w_cnt_b),
        .i_coef_a (w_coef_a),
        .i_exp_a  (w_exp_a),
        .i_coef_b (w_coef_b),
        .i_exp_b  (w_exp_b),
        .i_drop   (r_drop),
        .o_addr_a (w_addr_a),
        .o_addr_b (w_addr_b),
        .o_stat   (w_stat),
        .o_res    (o_res)
    );

endmodule

FILE: rtl/spa_chk.sv
// Port-level checker for the sparse polynomial adder, bound to the top level.
// Depends on spa_pkg for widths and command codes.
module spa_chk (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             i_in_ready,
    input logic [spa_pkg::CMD_W-1:0]        i_in_command,
    input logic                             i_res_valid,
    input logic                             i_res_ready,
    input logic signed [spa_pkg::SUM_W-1:0] i_res_coef,
    input logic                             i_res_term_valid,
    input logic                             i_res_last
);

    // a stalled result beat holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_coef)
            && $stable(i_res_last) && $stable(i_res_term_valid))
        else $error("result beat changed while stalled");

    // the empty-sum marker is the only beat of its run
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_term_valid |-> i_res_last && (i_res_coef == '0))
        else $error("empty-sum marker without last or with a coefficient");

    // a compute beat closes the input until its run ends
    a_busy_after_compute: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_command == spa_pkg::CMD_COMPUTE)
            |=> !i_in_ready)
        else $error("input ready right after a compute beat");

    // mid-run results only appear while the input is closed
    a_no_accept_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_last |-> !i_in_ready)
        else $error("input ready while a run is still producing results");

endmodule

bind sparse_polynomial_adder_top spa_chk u_spa_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_in_command     (i_in.command),
    .i_res_valid      (o_res.valid),
    .i_res_ready      (o_res.ready),
    .i_res_coef       (o_res.sum_coef),
    .i_res_term_valid (o_res.term_valid),
    .i_res_last       (o_res.last)
);
